FILE: sv/hkf_pkg.sv
// hkf_pkg: shared types and constants of the key report text framer
`timescale 1ns / 1ps

package hkf_pkg;

   // key codes of the boot keyboard usage table
   localparam logic [7:0] KEY_ENTER      = 8'h28;
   localparam logic [7:0] KEY_LETTER_LO  = 8'h04;
   localparam logic [7:0] KEY_LETTER_HI  = 8'h1d;
   localparam logic [7:0] KEY_DIGIT_LO   = 8'h1e;
   localparam logic [7:0] KEY_DIGIT_HI   = 8'h27;
   localparam logic [7:0] KEY_NONE       = 8'h00;
   localparam logic [7:0] KEY_ROLLOVER   = 8'h01;

   localparam logic [7:0] ASCII_UPPER_A  = 8'h41;
   localparam logic [7:0] ASCII_LOWER_A  = 8'h61;
   localparam logic [7:0] ASCII_ZERO     = 8'h30;
   localparam logic [7:0] ASCII_ONE      = 8'h31;
   localparam logic [7:0] ASCII_NUL      = 8'h00;

   localparam logic [7:0] START_MARKER_RESET = 8'h02;
   localparam logic [7:0] END_MARKER_RESET   = 8'h03;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [0:0] {
      CSR_START_MARKER = 1'b0,
      CSR_END_MARKER   = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      CMD_STORE = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   code;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_READ,
      BK_CHAR,
      BK_END
   } back_state_type;

   function automatic logic [7:0] key_to_ascii(input logic upper, input logic [7:0] key);
      logic [7:0] res;
      res = ASCII_NUL;
      if (key >= KEY_LETTER_LO && key <= KEY_LETTER_HI) begin
         res = (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + (key - KEY_LETTER_LO);
      end else if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI) begin
         if (key == KEY_DIGIT_HI) begin
            res = ASCII_ZERO;
         end else begin
            res = ASCII_ONE + (key - KEY_DIGIT_LO);
         end
      end
      return res;
   endfunction

endpackage

FILE: sv/hkf_req_if.sv
// hkf_req_if: keyboard report channel
`timescale 1ns / 1ps

interface hkf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key_pos2;
   logic [7:0] key_pos3;
   logic [7:0] key_pos4;
   logic [7:0] key_pos5;
   logic [7:0] key_pos6;
   logic [7:0] key_pos7;

   modport source (
      output valid, key_pos2, key_pos3, key_pos4, key_pos5, key_pos6, key_pos7,
      input  ready
   );
   modport sink (
      input  valid, key_pos2, key_pos3, key_pos4, key_pos5, key_pos6, key_pos7,
      output ready
   );
endinterface

FILE: sv/hkf_rsp_if.sv
// hkf_rsp_if: message byte channel
`timescale 1ns / 1ps

interface hkf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_last;

   modport source (
      output valid, out_byte, is_last,
      input  ready
   );
   modport sink (
      input  valid, out_byte, is_last,
      output ready
   );
endinterface

FILE: sv/hid_key_report_to_text_framer.sv
// hid_key_report_to_text_framer: keyboard report to framed text message top level
//
// req_chan takes one boot keyboard report per item (six key slots). A report
// whose first slot is 0 or 1 is taken and dropped. Otherwise the highest
// nonzero slot is the key: Enter flushes the stored text, any other key is
// mapped to ascii and stored (dropped once the store is full).
// rsp_chan gives the message bytes: start marker, stored characters up to the
// first stored zero, then the end marker with is_last set.
// Reports are classified combinationally and queued; a report is taken every
// cycle while the command queue has room. The back end takes one command per
// cycle while idle; a key lands in the store as it leaves the queue.
// A flush shows the start marker, then each character (store read, then output
// register), then the end marker; no command is taken until it is done.
// When the receiver stalls, the output register holds its byte and the back
// end waits; reports keep being taken until the queue is full.
// Reset clears the queue, the sequencer and the fill count and loads the
// markers with 2 and 3; the character store itself is not cleared.
// csr_we with csr_index writes the start or end marker; the user must do so
// only while idle, as the block does not enforce it.
`timescale 1ns / 1ps

module hid_key_report_to_text_framer #(
   parameter int CODE_CAPACITY = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  hkf_pkg::csr_index_type csr_index,
   input  logic [7:0]            csr_wdata,
   hkf_req_if.sink               req_chan,
   hkf_rsp_if.source             rsp_chan
);
   import hkf_pkg::*;

   logic [7:0] start_marker_ff;
   logic [7:0] end_marker_ff;
   logic       push_valid;
   cmd_type    push_cmd;
   logic       push_ready;
   logic       pop_valid;
   cmd_type    pop_cmd;
   logic       pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   hkf_front u_front (
      .req        (req_chan),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   hkf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop        (pop)
   );

   hkf_back #(
      .CODE_CAPACITY (CODE_CAPACITY)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (pop_valid),
      .cmd          (pop_cmd),
      .cmd_pop      (pop),
      .start_marker (start_marker_ff),
      .end_marker   (end_marker_ff),
      .rsp          (rsp_chan)
   );
endmodule

FILE: sv/hkf_ram.sv
// hkf_ram: generic single write port ram with registered read
`timescale 1ns / 1ps

module hkf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: sv/hkf_front.sv
// hkf_front: report qualification, key selection and ascii mapping
`timescale 1ns / 1ps

module hkf_front (
   hkf_req_if.sink          req,
   output logic             push_valid,
   output hkf_pkg::cmd_type push_cmd,
   input  logic             push_ready
);
   import hkf_pkg::*;

   logic [7:0] slot [6];
   logic [7:0] key;
   logic       upper;
   logic       voided;

   assign slot[0] = req.key_pos2;
   assign slot[1] = req.key_pos3;
   assign slot[2] = req.key_pos4;
   assign slot[3] = req.key_pos5;
   assign slot[4] = req.key_pos6;
   assign slot[5] = req.key_pos7;

   // highest nonzero slot wins; upper case unless it is the first slot
   always_comb begin
      key   = slot[0];
      upper = 1'b0;
      for (int i = 1; i < 6; i++) begin
         if (slot[i] != KEY_NONE) begin
            key   = slot[i];
            upper = 1'b1;
         end
      end
   end

   assign voided = (slot[0] == KEY_NONE) || (slot[0] == KEY_ROLLOVER);

   always_comb begin
      push_cmd.kind = (key == KEY_ENTER) ? CMD_FLUSH : CMD_STORE;
      push_cmd.code = key_to_ascii(upper, key);
   end

   // voided reports are taken and dropped
   assign push_valid = req.valid && !voided;
   assign req.ready  = push_ready;
endmodule

FILE: sv/hkf_queue.sv
// hkf_queue: short command queue between front and back
`timescale 1ns / 1ps

module hkf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  hkf_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             pop_valid,
   output hkf_pkg::cmd_type pop_cmd,
   input  logic             pop
);
   import hkf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

FILE: sv/hkf_back.sv
// hkf_back: character store and message emission sequencer
`timescale 1ns / 1ps

module hkf_back #(
   parameter int CODE_CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  hkf_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic [7:0]       start_marker,
   input  logic [7:0]       end_marker,
   hkf_rsp_if.source        rsp
);
   import hkf_pkg::*;

   localparam int CNT_W = $clog2(CODE_CAPACITY + 1);
   localparam int AW    = (CODE_CAPACITY > 1) ? $clog2(CODE_CAPACITY) : 1;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   logic             out_free;
   logic             ram_we;
   logic             ram_re;
   logic [7:0]       ram_rdata;

   hkf_ram #(
      .WIDTH (8),
      .DEPTH (CODE_CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[AW-1:0]),
      .wdata (cmd.code),
      .re    (ram_re),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign out_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.kind == CMD_FLUSH) begin
                  idx_in   = '0;
                  state_in = BK_START;
               end else if (fill_ff < CNT_W'(CODE_CAPACITY)) begin
                  // keys beyond capacity are dropped
                  ram_we  = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
         BK_START: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = start_marker;
               out_last_in  = 1'b0;
               state_in     = BK_READ;
            end
         end
         BK_READ: begin
            if (idx_ff < fill_ff) begin
               ram_re   = 1'b1;
               state_in = BK_CHAR;
            end else begin
               state_in = BK_END;
            end
         end
         BK_CHAR: begin
            // a stored zero ends the message early
            if (ram_rdata == ASCII_NUL) begin
               state_in = BK_END;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = ram_rdata;
               out_last_in  = 1'b0;
               idx_in       = idx_ff + CNT_W'(1);
               state_in     = BK_READ;
            end
         end
         BK_END: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_byte_in  = end_marker;
               out_last_in  = 1'b1;
               fill_in      = '0;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.out_byte = out_byte_ff;
   assign rsp.is_last  = out_last_ff;
endmodule

FILE: sv/hkf_checker.sv
// hkf_checker: port level assertions of the framer and their binding
`timescale 1ns / 1ps

module hkf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_last
);

   // a stalled item holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_is_last))
      else $error("rsp item changed while stalled");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a closing marker taken is never directly followed by another closing item
   a_last_twice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_last |=> !(rsp_valid && rsp_is_last))
      else $error("two closing items in a row");

   // the request side is not held off right after reset
   a_req_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req not ready after reset");

endmodule

bind hid_key_report_to_text_framer hkf_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_is_last  (rsp_chan.is_last)
);

FILE: verif/hkf_frame_checker.sv
// hkf_frame_checker: predicts and checks the message bytes of the key report framer
`timescale 1ns / 1ps

module hkf_frame_checker #(
   parameter int STORE_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  hkf_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_wdata,
   hkf_req_if                     req_mon,
   hkf_rsp_if                     rsp_mon,
   output int                     mismatch_count,
   output int                     owed_count,
   output int                     bytes_checked,
   output int                     frames_checked
);
   import hkf_pkg::*;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_last;
   } msg_byte_type;

   msg_byte_type owed_bytes[$];
   logic [7:0]   typed_chars[STORE_DEPTH];
   int           typed_count;
   logic [7:0]   start_mark;
   logic [7:0]   end_mark;

   function automatic logic [7:0] key_char(input logic shifted, input logic [7:0] key);
      if (key >= KEY_LETTER_LO && key <= KEY_LETTER_HI)
         return (shifted ? ASCII_UPPER_A : ASCII_LOWER_A) + (key - KEY_LETTER_LO);
      if (key == KEY_DIGIT_HI)
         return ASCII_ZERO;
      if (key >= KEY_DIGIT_LO && key < KEY_DIGIT_HI)
         return ASCII_ONE + (key - KEY_DIGIT_LO);
      return ASCII_NUL;
   endfunction

   // one report: drop it if voided, else store a character (if room) or queue the whole message on enter
   task automatic predict_report(input logic [5:0][7:0] slots);
      int         top_slot;
      logic [7:0] key;
      top_slot = 0;
      if (slots[0] == KEY_NONE || slots[0] == KEY_ROLLOVER)
         return;
      for (int i = 1; i < 6; i++)
         if (slots[i] != KEY_NONE)
            top_slot = i;
      key = slots[top_slot];
      if (key == KEY_ENTER) begin
         owed_bytes.push_back('{start_mark, 1'b0});
         for (int i = 0; i < typed_count; i++) begin
            if (typed_chars[i] == ASCII_NUL)
               break;
            owed_bytes.push_back('{typed_chars[i], 1'b0});
         end
         owed_bytes.push_back('{end_mark, 1'b1});
         typed_count = 0;
      end else if (typed_count < STORE_DEPTH) begin
         typed_chars[typed_count] = key_char(top_slot > 0, key);
         typed_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      msg_byte_type want;
      if (reset) begin
         owed_bytes.delete();
         typed_count    = 0;
         start_mark     = START_MARKER_RESET;
         end_mark       = END_MARKER_RESET;
         mismatch_count = 0;
         bytes_checked  = 0;
         frames_checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_MARKER: start_mark = csr_wdata;
               CSR_END_MARKER:   end_mark   = csr_wdata;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_report({req_mon.key_pos7, req_mon.key_pos6, req_mon.key_pos5,
                            req_mon.key_pos4, req_mon.key_pos3, req_mon.key_pos2});
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_bytes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected byte %02h last %0b", $realtime,
                           rsp_mon.out_byte, rsp_mon.is_last);
            end else begin
               want = owed_bytes.pop_front();
               bytes_checked++;
               if (rsp_mon.is_last === 1'b1)
                  frames_checked++;
               if (rsp_mon.out_byte !== want.text_byte || rsp_mon.is_last !== want.is_last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: byte %02h last %0b, expected byte %02h last %0b",
                              $realtime, rsp_mon.out_byte, rsp_mon.is_last,
                              want.text_byte, want.is_last);
               end
            end
         end
      end
      owed_count <= owed_bytes.size();
   end

endmodule

FILE: verif/testbench.sv
// testbench: stimulus and verdict for the key report to text framer
`timescale 1ns / 1ps

module testbench;
   import hkf_pkg::*;

   localparam int STORE_DEPTH   = 32;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 92;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   csr_index_type          csr_index;
   logic [7:0]             csr_wdata;
   int                     mismatch_count;
   int                     owed_count;
   int                     bytes_checked;
   int                     frames_checked;
   int                     send_idle_pct;
   int                     stall_pct;
   int                     reports_sent;

   hkf_req_if req_chan ();
   hkf_rsp_if rsp_chan ();

   hid_key_report_to_text_framer #(.CODE_CAPACITY(STORE_DEPTH)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   hkf_frame_checker #(.STORE_DEPTH(STORE_DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .owed_count     (owed_count),
      .bytes_checked  (bytes_checked),
      .frames_checked (frames_checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls at the current rate
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d bytes still owed", owed_count);
      $display("testbench NOT OK");
      $finish;
   end

   function automatic logic [5:0][7:0] report(input logic [7:0] s0, s1, s2, s3, s4, s5);
      return {s5, s4, s3, s2, s1, s0};
   endfunction

   // valid report with the key in slot pos, random slots below it, zeros above
   function automatic logic [5:0][7:0] key_report(input int pos, input logic [7:0] key);
      logic [5:0][7:0] slots;
      slots    = '0;
      slots[0] = 8'($urandom_range(2, 255));
      for (int i = 1; i < pos; i++)
         slots[i] = 8'($urandom_range(0, 255));
      slots[pos] = key;
      return slots;
   endfunction

   function automatic logic [5:0][7:0] noise_report(input bit voided);
      logic [5:0][7:0] slots;
      for (int i = 0; i < 6; i++)
         slots[i] = 8'($urandom_range(0, 255));
      if (voided)
         slots[0] = 8'($urandom_range(KEY_NONE, KEY_ROLLOVER));
      return slots;
   endfunction

   // clean keys are letters and digits only, so a full store shows in the message
   function automatic logic [7:0] typing_key(input bit clean);
      logic [7:0] key;
      int         pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         key = 8'($urandom_range(KEY_LETTER_LO, KEY_LETTER_HI));
      end else if (pick < 75 || clean) begin
         key = 8'($urandom_range(KEY_DIGIT_LO, KEY_DIGIT_HI));
      end else begin
         key = 8'($urandom_range(2, 255));
         if (key == KEY_ENTER)
            key = KEY_ENTER + 8'd1;
      end
      return key;
   endfunction

   task automatic send_report(input logic [5:0][7:0] slots);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.key_pos2 <= slots[0];
      req_chan.key_pos3 <= slots[1];
      req_chan.key_pos4 <= slots[2];
      req_chan.key_pos5 <= slots[3];
      req_chan.key_pos6 <= slots[4];
      req_chan.key_pos7 <= slots[5];
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      if (slots[0] != KEY_NONE && slots[0] != KEY_ROLLOVER)
         reports_sent++;
   endtask

   task automatic type_line(input int keys, input bit clean);
      for (int k = 0; k < keys; k++) begin
         if ($urandom_range(0, 11) == 0)
            send_report(noise_report(1'b1));
         send_report(key_report($urandom_range(0, 5), typing_key(clean)));
      end
      send_report(key_report($urandom_range(0, 5), KEY_ENTER));
   endtask

   // hold the sender until every owed byte is out and the block has settled
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_markers(input logic [7:0] start_byte, input logic [7:0] end_byte);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_START_MARKER;
      csr_wdata <= start_byte;
      @(posedge clock);
      csr_index <= CSR_END_MARKER;
      csr_wdata <= end_byte;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      int phase_goal;
      int line_keys;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_START_MARKER;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.key_pos2 <= '0;
      req_chan.key_pos3 <= '0;
      req_chan.key_pos4 <= '0;
      req_chan.key_pos5 <= '0;
      req_chan.key_pos6 <= '0;
      req_chan.key_pos7 <= '0;
      stall_pct         <= 0;
      send_idle_pct = 0;
      reports_sent  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // voided reports, even with enter in them
      send_report(report(KEY_NONE, KEY_ENTER, 8'hff, 8'h04, 8'h1e, KEY_ENTER));
      send_report(report(KEY_ROLLOVER, 8'h04, 8'h00, 8'h00, 8'h00, KEY_ENTER));
      // enter on an empty store
      send_report(report(KEY_ENTER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // letter and digit edges, first slot and later slots
      send_report(report(KEY_LETTER_LO, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(KEY_LETTER_HI, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(8'hff, KEY_LETTER_LO, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(8'h02, 8'h10, 8'h33, 8'h00, 8'h00, KEY_LETTER_HI));
      send_report(report(KEY_DIGIT_LO, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(8'h05, 8'h00, 8'h26, 8'h00, 8'h00, 8'h00));
      send_report(report(KEY_DIGIT_HI, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, KEY_ENTER));
      // a zero-mapped key cuts the message short
      send_report(report(8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
      send_report(report(8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(8'h02, 8'h00, 8'h00, KEY_ENTER, 8'h00, 8'h00));
      send_report(report(KEY_ENTER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      // just outside the letter and digit ranges
      send_report(report(8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(report(KEY_ENTER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      drain();
      // overfill the store
      type_line(STORE_DEPTH + 2, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1: write_markers(8'h00, 8'hff);
            2: write_markers(8'hff, 8'h00);
            3: write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default: ;
         endcase
         send_idle_pct = (phase == 1) ? 62 : (phase == 3) ? 9 : 0;
         stall_pct <= (phase == 2) ? 62 : (phase == 3) ? 9 : 0;
         phase_goal = reports_sent + PHASE_ITEMS;
         while (reports_sent < phase_goal) begin
            case ($urandom_range(0, 9))
               0: begin
                  repeat ($urandom_range(1, 4)) send_report(noise_report(1'b0));
               end
               1: begin
                  // line abandoned without enter, the next one carries on
                  repeat ($urandom_range(1, 5))
                     send_report(key_report($urandom_range(0, 5), typing_key(1'b0)));
               end
               default: begin
                  line_keys = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40)
                                                          : $urandom_range(0, 10);
                  type_line(line_keys, 1'($urandom_range(0, 1)));
               end
            endcase
            if (phase == 0 && $urandom_range(0, 19) == 0)
               drain();
         end
      end

      drain();
      $display("sent %0d key reports over four handshake mixes and three marker settings",
               reports_sent);
      $display("checked %0d message bytes in %0d messages", bytes_checked, frames_checked);
      if (mismatch_count == 0 && owed_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches, %0d bytes still owed", mismatch_count, owed_count);
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
